### hw/rtl/csp_pkg.sv
// Shared types and constants for the CDMA SMS PDU parser.
`default_nettype none

package csp_pkg;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_DIGIT  = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_TSTAMP = 2'd2,
    KIND_STATUS = 2'd3
  } item_kind_e;

  // Final status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_HEADER    = 3'd1,
    STAT_ADDRESS   = 3'd2,
    STAT_TRUNCATED = 3'd3,
    STAT_ENCODING  = 3'd4,
    STAT_TOO_LONG  = 3'd5,
    STAT_SHORT_TS  = 3'd6
  } status_e;

  // Parameter ids and encodings
  localparam logic [7:0] OA_PARAM_ID  = 8'h02;
  localparam logic [7:0] BD_PARAM_ID  = 8'h08;
  localparam logic [7:0] SUB_USERDATA = 8'h01;
  localparam logic [7:0] SUB_TSTAMP   = 8'h03;
  localparam logic [4:0] DCS_SEPTET   = 5'h02;
  localparam logic [4:0] DCS_UCS2     = 5'h04;
  localparam logic [7:0] MAX_SEPTETS  = 8'd160;
  localparam logic [7:0] MAX_UCS2     = 8'd70;
  localparam logic [7:0] TS_FIELDS    = 8'd6;

  // Units captured before the concatenation header check resolves
  localparam int unsigned HOLD_DEPTH = 3;

  // One non-status result
  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  value;
    logic [7:0]  index;
    logic        enc;
  } payload_t;

  // Fixed teleservice header 00 00 02 10 02
  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] r;
    begin
      case (pos)
        3'd2:    r = 8'h02;
        3'd3:    r = 8'h10;
        3'd4:    r = 8'h02;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

  // Concatenation header mark 05 00 03
  function automatic logic [7:0] mark_byte(input logic [1:0] pos);
    logic [7:0] r;
    begin
      case (pos)
        2'd0:    r = 8'h05;
        2'd2:    r = 8'h03;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/csp_in_if.sv
// Input byte channel of the SMS PDU parser.
`default_nettype none

interface csp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_pdu;

  modport source (output valid, output data_byte, output end_of_pdu, input ready);
  modport sink   (input valid, input data_byte, input end_of_pdu, output ready);
endinterface

`default_nettype wire

### hw/rtl/csp_out_if.sv
// Result item channel of the SMS PDU parser.
`default_nettype none

interface csp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] item_value;
  logic [7:0] item_index;
  logic       text_encoding;
  logic [2:0] status_code;
  logic       last_item;

  modport source (output valid, output item_kind, output item_value, output item_index,
                  output text_encoding, output status_code, output last_item,
                  input ready);
  modport sink   (input valid, input item_kind, input item_value, input item_index,
                  input text_encoding, input status_code, input last_item,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/cdma_sms_pdu_parser.sv
// Top level of the CDMA point-to-point SMS PDU parser.
// The parser takes one PDU byte per transaction and decodes it combinationally
// into at most three payload items plus an optional status item, which
// are loaded into a four-slot result register. Slots drain one per cycle in
// order while the output is ready. The input is ready only when no result
// stays after the current pop, so a byte that yields several results holds
// the input channel while the result register drains (at most four: three
// units released by a failed concatenation header check, plus a status).
`default_nettype none

module cdma_sms_pdu_parser #(
  parameter int unsigned ADDR_CAPACITY = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csp_in_if.sink    pdu_i,
  csp_out_if.source res_o
);

  typedef enum logic [3:0] {
    PH_H0, PH_H1, PH_H2, PH_H3, PH_H4,
    PH_OA_ID, PH_OA_LEN, PH_OA, PH_SKIP3, PH_BD_ID, PH_BD_LEN,
    PH_SUB_TYPE, PH_SUB_LEN, PH_UD, PH_TS, PH_OTHER
  } phase_e;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  fbl_q, fbl_d;
  logic [15:0] acc_q, acc_d;
  logic [4:0]  bh_q, bh_d;
  logic [7:0]  utd_q, utd_d;
  logic [7:0]  done_q, done_d;
  logic [1:0]  seen_q, seen_d;
  logic        fin_q, fin_d;
  logic [7:0]  fpos_q, fpos_d;
  logic [1:0]  held_q, held_d;
  logic        match_q, match_d;
  logic [2:0]  drop_q, drop_d;
  logic        holding_q, holding_d;
  logic        enc_q, enc_d;
  logic [7:0]  sub_q, sub_d;
  logic [7:0]  store_q [HOLD_DEPTH_L];
  logic [7:0]  store_d [HOLD_DEPTH_L];

  localparam int unsigned HOLD_DEPTH_L = csp_pkg::HOLD_DEPTH;

  // Result slots: three payload, one status
  csp_pkg::payload_t pl_q [3];
  csp_pkg::payload_t pl_d [3];
  csp_pkg::status_e  st_q, st_d;
  logic [3:0]        vld_q, vld_new, pop_mask, vld_left;
  logic              in_fire, out_fire;

  // Decode scratch
  logic [7:0]  b;
  logic [1:0]  n;
  logic        st_vld, failed;
  logic [7:0]  tellen, smlen, octet, uval, idx, tens;
  logic [15:0] sh;
  logic [3:0]  dig;

  assign out_fire = res_o.valid && res_o.ready;
  assign pop_mask = out_fire ? (vld_q & ~(vld_q - 4'd1)) : 4'd0;
  assign vld_left = vld_q & ~pop_mask;
  assign pdu_i.ready = (vld_left == 4'd0);
  assign in_fire  = pdu_i.valid && pdu_i.ready;

  // Per-byte decode
  always_comb begin
    phase_d = phase_q; fbl_d = fbl_q; acc_d = acc_q; bh_d = bh_q;
    utd_d = utd_q; done_d = done_q; seen_d = seen_q; fin_d = fin_q;
    fpos_d = fpos_q; held_d = held_q; match_d = match_q; drop_d = drop_q;
    holding_d = holding_q; enc_d = enc_q; sub_d = sub_q;
    store_d = store_q;
    for (int k = 0; k < 3; k++) pl_d[k] = '0;
    st_d = csp_pkg::STAT_OK; st_vld = 1'b0; failed = 1'b0; n = 2'd0;
    b = pdu_i.data_byte;
    tellen = '0; smlen = '0; octet = '0; uval = '0; idx = '0; tens = '0;
    sh = '0; dig = '0;

    if (!fin_q) begin
      unique case (phase_q)
        PH_H0, PH_H1, PH_H2, PH_H3, PH_H4: begin
          if (b != csp_pkg::hdr_byte(phase_q[2:0])) begin
            st_vld = 1'b1; st_d = csp_pkg::STAT_HEADER; fin_d = 1'b1;
          end else begin
            phase_d = phase_e'(phase_q + 4'd1);
          end
        end
        PH_OA_ID: begin
          if (b != csp_pkg::OA_PARAM_ID) begin
            st_vld = 1'b1; st_d = csp_pkg::STAT_ADDRESS; fin_d = 1'b1;
          end else begin
            phase_d = PH_OA_LEN;
          end
        end
        PH_OA_LEN: begin
          if (b < 8'd2) begin
            st_vld = 1'b1; st_d = csp_pkg::STAT_ADDRESS; fin_d = 1'b1;
          end else begin
            fbl_d = b; fpos_d = '0; done_d = '0; utd_d = '0; bh_d = '0;
            phase_d = PH_OA;
          end
        end
        PH_OA: begin
          if (fpos_q == 8'd0) begin
            if (|b[7:6]) begin
              failed = 1'b1;
            end else begin
              acc_d = {8'h00, b};
            end
          end else begin
            if (fpos_q == 8'd1) begin
              tellen = {acc_q[5:0], b[7:6]};
              if (tellen >= 8'(ADDR_CAPACITY)) begin
                failed = 1'b1;
              end else begin
                utd_d = tellen; done_d = '0;
                acc_d = {10'h000, b[5:0]}; bh_d = 5'd6;
              end
            end else if (done_q < utd_q) begin
              acc_d = {acc_q[7:0], b};
              bh_d  = bh_q + 5'd8;
            end
            // up to two digits per byte
            if (!failed) begin
              for (int k = 0; k < 2; k++) begin
                if (bh_d >= 5'd4 && done_d < utd_d) begin
                  sh  = acc_d >> (bh_d - 5'd4);
                  dig = sh[3:0];
                  if (dig > 4'd9) dig = dig - 4'd10;
                  pl_d[n] = '{kind: csp_pkg::KIND_DIGIT, value: 8'h30 + {4'h0, dig},
                              index: done_d, enc: 1'b0};
                  n = n + 2'd1;
                  done_d = done_d + 8'd1;
                  bh_d = bh_d - 5'd4;
                end
              end
            end
          end
          if (failed) begin
            st_vld = 1'b1; st_d = csp_pkg::STAT_ADDRESS; fin_d = 1'b1;
          end else begin
            fpos_d = fpos_q + 8'd1;
            fbl_d  = fbl_q - 8'd1;
            if (fbl_d == 8'd0) begin
              if (done_d < utd_d) begin
                st_vld = 1'b1; st_d = csp_pkg::STAT_ADDRESS; fin_d = 1'b1;
              end else begin
                fbl_d = 8'd3; phase_d = PH_SKIP3;
              end
            end
          end
        end
        PH_SKIP3: begin
          fbl_d = fbl_q - 8'd1;
          if (fbl_d == 8'd0) phase_d = PH_BD_ID;
        end
        PH_BD_ID: begin
          if (b != csp_pkg::BD_PARAM_ID) begin
            st_vld = 1'b1; st_d = csp_pkg::STAT_HEADER; fin_d = 1'b1;
          end else begin
            phase_d = PH_BD_LEN;
          end
        end
        PH_BD_LEN: phase_d = PH_SUB_TYPE;
        PH_SUB_TYPE: begin
          sub_d = b; phase_d = PH_SUB_LEN;
        end
        PH_SUB_LEN: begin
          fbl_d = b; fpos_d = '0;
          if (sub_q == csp_pkg::SUB_USERDATA) begin
            if (b < 8'd2) begin
              st_vld = 1'b1; st_d = csp_pkg::STAT_TRUNCATED; fin_d = 1'b1;
            end else begin
              phase_d = PH_UD;
            end
          end else if (sub_q == csp_pkg::SUB_TSTAMP) begin
            if (b < csp_pkg::TS_FIELDS) begin
              st_vld = 1'b1; st_d = csp_pkg::STAT_SHORT_TS; fin_d = 1'b1;
            end else begin
              phase_d = PH_TS;
            end
          end else begin
            phase_d = (b == 8'd0) ? PH_SUB_TYPE : PH_OTHER;
          end
        end
        PH_UD: begin
          if (fpos_q == 8'd0) begin
            // encoding field
            if (b[7:3] == csp_pkg::DCS_SEPTET) begin
              enc_d = 1'b0; acc_d = {8'h00, b};
            end else if (b[7:3] == csp_pkg::DCS_UCS2) begin
              enc_d = 1'b1; acc_d = {8'h00, b};
            end else begin
              failed = 1'b1;
              st_vld = 1'b1; st_d = csp_pkg::STAT_ENCODING; fin_d = 1'b1;
            end
          end else if (fpos_q == 8'd1) begin
            // unit count, checked before doubling
            smlen = {acc_q[2:0], b[7:3]};
            if ((!enc_q && smlen > csp_pkg::MAX_SEPTETS) ||
                (enc_q && smlen > csp_pkg::MAX_UCS2)) begin
              failed = 1'b1;
              st_vld = 1'b1; st_d = csp_pkg::STAT_TOO_LONG; fin_d = 1'b1;
            end else begin
              utd_d = enc_q ? {smlen[6:0], 1'b0} : smlen;
              done_d = '0; drop_d = '0; held_d = '0; match_d = 1'b1;
              holding_d = enc_q ? (utd_d >= 8'd6) : (smlen >= 8'd7);
              acc_d = {8'h00, b}; bh_d = 5'd3;
            end
          end else if (done_q < utd_q) begin
            acc_d = {acc_q[7:0], b};
            octet = acc_d[10:3];
            if (holding_q && fpos_q <= 8'd4 &&
                octet != csp_pkg::mark_byte(2'(fpos_q - 8'd2)))
              match_d = 1'b0;
            if (!enc_q) bh_d = bh_q + 5'd8;
            // one octet or up to two septets
            for (int k = 0; k < 2; k++) begin
              uval = 8'h00;
              if (enc_q ? (k == 0) : (bh_d >= 5'd7 && done_d < utd_d)) begin
                if (enc_q) begin
                  uval = octet;
                end else begin
                  sh = acc_d >> (bh_d - 5'd7);
                  uval = {1'b0, sh[6:0]};
                  bh_d = bh_d - 5'd7;
                end
                idx = done_d;
                done_d = done_d + 8'd1;
                if (holding_q) begin
                  if (held_d < 2'(HOLD_DEPTH_L)) begin
                    store_d[held_d] = uval;
                    held_d = held_d + 2'd1;
                  end
                end else if (idx >= {5'd0, drop_q}) begin
                  pl_d[n] = '{kind: csp_pkg::KIND_TEXT, value: uval,
                              index: idx - {5'd0, drop_q}, enc: enc_q};
                  n = n + 2'd1;
                end
              end
            end
            // concatenation header check resolves on the third octet
            if (holding_q && fpos_q == 8'd4) begin
              holding_d = 1'b0;
              if (match_d) begin
                drop_d = enc_q ? 3'd6 : 3'd7;
                if (!enc_q && utd_q == 8'd7) utd_d = done_d;
              end else begin
                for (int k = 0; k < 3; k++) begin
                  if (2'(k) < held_d) begin
                    pl_d[n] = '{kind: csp_pkg::KIND_TEXT, value: store_d[k],
                                index: 8'(k), enc: enc_q};
                    n = n + 2'd1;
                  end
                end
              end
              held_d = '0;
            end
          end
          if (!failed) begin
            fpos_d = fpos_q + 8'd1;
            fbl_d  = fbl_q - 8'd1;
            if (fbl_d == 8'd0) begin
              if (holding_d || done_d < utd_d) begin
                st_vld = 1'b1; st_d = csp_pkg::STAT_TRUNCATED; fin_d = 1'b1;
              end else begin
                seen_d = seen_q | 2'b01;
                if (seen_d == 2'b11) begin
                  st_vld = 1'b1; st_d = csp_pkg::STAT_OK; fin_d = 1'b1;
                end else begin
                  phase_d = PH_SUB_TYPE;
                end
              end
            end
          end
        end
        PH_TS: begin
          if (fpos_q < csp_pkg::TS_FIELDS) begin
            tens = {4'h0, b[7:4]};
            pl_d[n] = '{kind: csp_pkg::KIND_TSTAMP,
                        value: {4'h0, b[3:0]} + (tens << 3) + (tens << 1),
                        index: fpos_q, enc: 1'b0};
            n = n + 2'd1;
          end
          fpos_d = fpos_q + 8'd1;
          fbl_d  = fbl_q - 8'd1;
          if (fbl_d == 8'd0) begin
            seen_d = seen_q | 2'b10;
            if (seen_d == 2'b11) begin
              st_vld = 1'b1; st_d = csp_pkg::STAT_OK; fin_d = 1'b1;
            end else begin
              phase_d = PH_SUB_TYPE;
            end
          end
        end
        PH_OTHER: begin
          fbl_d = fbl_q - 8'd1;
          if (fbl_d == 8'd0) begin
            if (seen_q == 2'b11) begin
              st_vld = 1'b1; st_d = csp_pkg::STAT_OK; fin_d = 1'b1;
            end else begin
              phase_d = PH_SUB_TYPE;
            end
          end
        end
        default: begin
          st_vld = 1'b1; st_d = csp_pkg::STAT_HEADER; fin_d = 1'b1;
        end
      endcase
    end

    // End of PDU: close with truncated status unless already finished, then restart
    if (pdu_i.end_of_pdu) begin
      if (!fin_d) begin
        st_vld = 1'b1; st_d = csp_pkg::STAT_TRUNCATED;
      end
      phase_d = PH_H0; fbl_d = '0; acc_d = '0; bh_d = '0; utd_d = '0;
      done_d = '0; seen_d = '0; fin_d = 1'b0; fpos_d = '0; held_d = '0;
      match_d = 1'b0; drop_d = '0; holding_d = 1'b0; enc_d = 1'b0; sub_d = '0;
    end

    vld_new = {st_vld, (n > 2'd2), (n > 2'd1), (n > 2'd0)};
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H0; fbl_q <= '0; acc_q <= '0; bh_q <= '0; utd_q <= '0;
      done_q <= '0; seen_q <= '0; fin_q <= 1'b0; fpos_q <= '0; held_q <= '0;
      match_q <= 1'b0; drop_q <= '0; holding_q <= 1'b0; enc_q <= 1'b0;
      sub_q <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d; fbl_q <= fbl_d; acc_q <= acc_d; bh_q <= bh_d;
      utd_q <= utd_d; done_q <= done_d; seen_q <= seen_d; fin_q <= fin_d;
      fpos_q <= fpos_d; held_q <= held_d; match_q <= match_d; drop_q <= drop_d;
      holding_q <= holding_d; enc_q <= enc_d; sub_q <= sub_d;
    end
  end

  // Holdback store, result payload slots and status slot
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      store_q <= store_d;
      pl_q    <= pl_d;
      st_q    <= st_d;
    end
  end

  // Result slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (in_fire) begin
      vld_q <= vld_new;
    end else begin
      vld_q <= vld_left;
    end
  end

  // Output: lowest valid slot first, status last
  always_comb begin
    res_o.valid         = |vld_q;
    res_o.item_kind     = csp_pkg::KIND_STATUS;
    res_o.item_value    = '0;
    res_o.item_index    = '0;
    res_o.text_encoding = 1'b0;
    res_o.status_code   = '0;
    res_o.last_item     = 1'b0;
    if (vld_q[0]) begin
      res_o.item_kind = pl_q[0].kind; res_o.item_value = pl_q[0].value;
      res_o.item_index = pl_q[0].index; res_o.text_encoding = pl_q[0].enc;
    end else if (vld_q[1]) begin
      res_o.item_kind = pl_q[1].kind; res_o.item_value = pl_q[1].value;
      res_o.item_index = pl_q[1].index; res_o.text_encoding = pl_q[1].enc;
    end else if (vld_q[2]) begin
      res_o.item_kind = pl_q[2].kind; res_o.item_value = pl_q[2].value;
      res_o.item_index = pl_q[2].index; res_o.text_encoding = pl_q[2].enc;
    end else begin
      res_o.status_code = st_q;
      res_o.last_item   = 1'b1;
    end
  end

  // A stalled result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !pdu_i.ready)
    else $error("input accepted while a result is stalled");

  // last_item marks exactly the status items
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.last_item == (res_o.item_kind == csp_pkg::KIND_STATUS)))
    else $error("last_item does not match status kind");

  // Held units never exceed the holdback store
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holding_q |-> (held_q <= 2'(HOLD_DEPTH_L)))
    else $error("holdback count overflow");

endmodule

`default_nettype wire

### tb/tb_cdma_sms_pdu_parser.sv
// Self-checking testbench for the CDMA SMS PDU parser: random PDUs, scoreboard, idling phases.
`timescale 1ns / 100ps

import csp_pkg::*;

// Byte-level parse phases of the scoreboard's decoder
typedef enum logic [4:0] {
  PH_HDR0   = 5'd0,
  PH_OA_ID  = 5'd5,
  PH_OA_LEN = 5'd6,
  PH_OA     = 5'd7,
  PH_SKIP3  = 5'd8,
  PH_BD_ID  = 5'd9,
  PH_BD_LEN = 5'd10,
  PH_SUB_TY = 5'd11,
  PH_SUB_LN = 5'd12,
  PH_UD     = 5'd13,
  PH_TS     = 5'd14,
  PH_OTHER  = 5'd15
} parse_ph_e;

class sms_scoreboard;
  typedef struct {
    item_kind_e kind;
    logic [7:0] value;
    logic [7:0] index;
    logic       enc;
    status_e    status;
    logic       last;
  } sms_item_t;

  sms_item_t  expected_items[$];
  int         errors;
  int         addr_cap;

  // decoder state
  logic [4:0]  phase;
  logic [7:0]  bytes_left;
  logic [15:0] acc;
  logic [4:0]  bits_held;
  logic [7:0]  units_total;
  logic [7:0]  units_done;
  logic [7:0]  held_units [7];
  logic [1:0]  seen;
  logic        finished;
  logic [7:0]  fpos, held_cnt, drop_cnt, sub_type;
  logic        hdr_ok, holding, ucs2;
  int          step_items;

  function new(int cap);
    addr_cap = cap;
    errors   = 0;
    for (int k = 0; k < 7; k++) held_units[k] = '0;
    restart();
  endfunction

  function void restart();
    phase = PH_HDR0; bytes_left = 0; acc = 0; bits_held = 0;
    units_total = 0; units_done = 0; seen = 0; finished = 0;
    fpos = 0; held_cnt = 0; hdr_ok = 0; drop_cnt = 0; holding = 0; ucs2 = 0; sub_type = 0;
  endfunction

  function void push_item(item_kind_e k, logic [7:0] v, logic [7:0] i, logic e,
                          status_e s, logic l);
    sms_item_t it;
    if (step_items >= 10) return;
    it.kind = k; it.value = v; it.index = i; it.enc = e; it.status = s; it.last = l;
    expected_items.push_back(it);
    step_items++;
  endfunction

  function void finish_with(status_e s);
    push_item(KIND_STATUS, 8'd0, 8'd0, 1'b0, s, 1'b1);
    finished = 1;
  endfunction

  function void subparam_done();
    if (seen == 2'b11) finish_with(STAT_OK);
    else phase = PH_SUB_TY;
  endfunction

  function void text_unit(logic [7:0] v);
    logic [7:0] idx;
    idx = units_done;
    units_done++;
    if (holding) begin
      if (held_cnt < 7) begin
        held_units[held_cnt] = v;
        held_cnt++;
      end
    end else if (idx >= drop_cnt) begin
      push_item(KIND_TEXT, v, idx - drop_cnt, ucs2, STAT_OK, 1'b0);
    end
  endfunction

  // User data body: encoding, unit count, then packed units
  function void user_data_byte(logic [7:0] b);
    logic [7:0] smlen, octet;
    logic [7:0] mark;
    if (fpos == 0) begin
      if (b[7:3] == DCS_SEPTET) ucs2 = 0;
      else if (b[7:3] == DCS_UCS2) ucs2 = 1;
      else begin finish_with(STAT_ENCODING); return; end
      acc = {8'd0, b};
    end else if (fpos == 1) begin
      smlen = {acc[2:0], b[7:3]};
      if (!ucs2 && smlen > MAX_SEPTETS) begin finish_with(STAT_TOO_LONG); return; end
      if (ucs2 && smlen > MAX_UCS2) begin finish_with(STAT_TOO_LONG); return; end
      units_total = ucs2 ? smlen * 2 : smlen;
      units_done = 0; drop_cnt = 0; held_cnt = 0; hdr_ok = 1;
      holding = ucs2 ? (units_total >= 6) : (smlen >= 7);
      acc = {8'd0, b};
      bits_held = 3;
    end else if (units_done < units_total) begin
      acc = {acc[7:0], b};
      octet = acc[10:3];
      case (fpos)
        8'd2:    mark = 8'h05;
        8'd3:    mark = 8'h00;
        default: mark = 8'h03;
      endcase
      if (holding && fpos <= 4 && octet != mark) hdr_ok = 0;
      if (ucs2) begin
        text_unit(octet);
      end else begin
        bits_held += 8;
        while (bits_held >= 7 && units_done < units_total) begin
          text_unit((acc >> (bits_held - 7)) & 16'h7f);
          bits_held -= 7;
        end
      end
      if (holding && fpos == 4) begin
        holding = 0;
        if (hdr_ok) begin
          drop_cnt = ucs2 ? 8'd6 : 8'd7;
          if (!ucs2 && units_total == 7) units_total = units_done;
        end else begin
          for (int k = 0; k < held_cnt && k < 7; k++)
            push_item(KIND_TEXT, held_units[k], k[7:0], ucs2, STAT_OK, 1'b0);
        end
        held_cnt = 0;
      end
    end
  endfunction

  // Originating address: digit count at 2-bit offset, then 4-bit digits
  function void address_byte(logic [7:0] b);
    logic [7:0] tellen;
    logic [3:0] d;
    if (fpos == 0) begin
      if (b[7:6] != 2'b00) begin finish_with(STAT_ADDRESS); return; end
      acc = {8'd0, b};
      return;
    end
    if (fpos == 1) begin
      tellen = {acc[5:0], b[7:6]};
      if (tellen >= addr_cap) begin finish_with(STAT_ADDRESS); return; end
      units_total = tellen; units_done = 0;
      acc = {10'd0, b[5:0]};
      bits_held = 6;
    end else if (units_done < units_total) begin
      acc = {acc[7:0], b};
      bits_held += 8;
    end
    while (bits_held >= 4 && units_done < units_total) begin
      d = (acc >> (bits_held - 4)) & 16'hf;
      if (d > 9) d = d - 10;
      push_item(KIND_DIGIT, 8'h30 + d, units_done, 1'b0, STAT_OK, 1'b0);
      units_done++;
      bits_held -= 4;
    end
  endfunction

  function void parse_byte(logic [7:0] b);
    logic [7:0] hb;
    case (phase)
      PH_OA_ID: if (b != OA_PARAM_ID) finish_with(STAT_ADDRESS); else phase = PH_OA_LEN;
      PH_OA_LEN: begin
        if (b < 2) finish_with(STAT_ADDRESS);
        else begin
          bytes_left = b; fpos = 0; units_done = 0; units_total = 0; bits_held = 0;
          phase = PH_OA;
        end
      end
      PH_OA: begin
        address_byte(b);
        if (!finished) begin
          fpos++; bytes_left--;
          if (bytes_left == 0) begin
            if (units_done < units_total) finish_with(STAT_ADDRESS);
            else begin bytes_left = 3; phase = PH_SKIP3; end
          end
        end
      end
      PH_SKIP3: begin
        bytes_left--;
        if (bytes_left == 0) phase = PH_BD_ID;
      end
      PH_BD_ID: if (b != BD_PARAM_ID) finish_with(STAT_HEADER); else phase = PH_BD_LEN;
      PH_BD_LEN: phase = PH_SUB_TY;
      PH_SUB_TY: begin sub_type = b; phase = PH_SUB_LN; end
      PH_SUB_LN: begin
        bytes_left = b; fpos = 0;
        if (sub_type == SUB_USERDATA) begin
          if (b < 2) finish_with(STAT_TRUNCATED); else phase = PH_UD;
        end else if (sub_type == SUB_TSTAMP) begin
          if (b < TS_FIELDS) finish_with(STAT_SHORT_TS); else phase = PH_TS;
        end else begin
          phase = (b == 0) ? PH_SUB_TY : PH_OTHER;
        end
      end
      PH_UD: begin
        user_data_byte(b);
        if (!finished) begin
          fpos++; bytes_left--;
          if (bytes_left == 0) begin
            if (holding || units_done < units_total) finish_with(STAT_TRUNCATED);
            else begin seen[0] = 1; subparam_done(); end
          end
        end
      end
      PH_TS: begin
        if (fpos < 6)
          push_item(KIND_TSTAMP, b[3:0] + b[7:4] * 8'd10, fpos, 1'b0, STAT_OK, 1'b0);
        fpos++; bytes_left--;
        if (bytes_left == 0) begin seen[1] = 1; subparam_done(); end
      end
      PH_OTHER: begin
        bytes_left--;
        if (bytes_left == 0) subparam_done();
      end
      default: begin
        if (phase < 5) begin
          case (phase)
            5'd2, 5'd4: hb = 8'h02;
            5'd3:       hb = 8'h10;
            default:    hb = 8'h00;
          endcase
          if (b != hb) finish_with(STAT_HEADER); else phase++;
        end else begin
          finish_with(STAT_HEADER);
        end
      end
    endcase
  endfunction

  // Accepted input transaction
  function void note_byte(logic [7:0] b, logic eop);
    step_items = 0;
    if (!finished) parse_byte(b);
    if (eop) begin
      if (!finished) finish_with(STAT_TRUNCATED);
      restart();
    end
  endfunction

  // Accepted output transaction
  function void check_item(logic [1:0] k, logic [7:0] v, logic [7:0] i, logic e,
                           logic [2:0] s, logic l);
    sms_item_t x;
    if (expected_items.size() == 0) begin
      $error("unexpected result item kind=%0d value=%0h", k, v);
      errors++;
      return;
    end
    x = expected_items.pop_front();
    if (k !== x.kind) begin $error("item_kind exp %0d got %0d", x.kind, k); errors++; end
    if (v !== x.value) begin $error("item_value exp %0h got %0h", x.value, v); errors++; end
    if (i !== x.index) begin $error("item_index exp %0d got %0d", x.index, i); errors++; end
    if (e !== x.enc) begin $error("text_encoding exp %0d got %0d", x.enc, e); errors++; end
    if (s !== x.status) begin $error("status_code exp %0d got %0d", x.status, s); errors++; end
    if (l !== x.last) begin $error("last_item exp %0d got %0d", x.last, l); errors++; end
  endfunction

  function int pending();
    return expected_items.size();
  endfunction
endclass

module tb_cdma_sms_pdu_parser;
  localparam int ADDR_CAP = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;

  csp_in_if  pdu_if ();
  csp_out_if res_if ();

  cdma_sms_pdu_parser #(.ADDR_CAPACITY(ADDR_CAP)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pdu_i  (pdu_if),
    .res_o  (res_if)
  );

  sms_scoreboard sb = new(ADDR_CAP);

  int idle_pct, stall_pct, cycles, bytes_sent;
  bit          bitq [$];
  logic [7:0]  body_q [$];
  logic [7:0]  pdu_q [$];

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_cdma_sms_pdu_parser: FAIL");
      $finish;
    end
  end

  // Result monitor and random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready)
        sb.check_item(res_if.item_kind, res_if.item_value, res_if.item_index,
                      res_if.text_encoding, res_if.status_code, res_if.last_item);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Drive one byte and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic eop);
    pdu_if.valid      <= 1'b1;
    pdu_if.data_byte  <= b;
    pdu_if.end_of_pdu <= eop;
    do @(posedge clk_i); while (!pdu_if.ready);
    sb.note_byte(b, eop);
    bytes_sent++;
    if ($urandom_range(99) < idle_pct) begin
      pdu_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_pdu();
    foreach (pdu_q[k]) send_byte(pdu_q[k], k == pdu_q.size() - 1);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void put_bits(int unsigned v, int n);
    for (int k = n - 1; k >= 0; k--) bitq.push_back((v >> k) & 1);
  endfunction

  // Pack the bit queue MSB first into body_q, zero padded
  function automatic void pack_body();
    logic [7:0] b;
    body_q.delete();
    while (bitq.size() % 8 != 0) bitq.push_back(1'b0);
    while (bitq.size() != 0) begin
      b = '0;
      for (int k = 0; k < 8; k++) b = {b[6:0], bitq.pop_front()};
      body_q.push_back(b);
    end
  endfunction

  // Body length, sometimes short or padded
  function automatic int skew_len(int n);
    int r;
    r = $urandom_range(99);
    if (r < 8 && n > 2) return n - 1;
    if (r < 14) return n + $urandom_range(1, 2);
    return n;
  endfunction

  function automatic void add_body(int len);
    for (int k = 0; k < len; k++)
      pdu_q.push_back(k < body_q.size() ? body_q[k] : 8'($urandom));
  endfunction

  function automatic void add_user_data();
    int n, w, r, len;
    logic [4:0] dcs;
    bit concat;
    r = $urandom_range(99);
    dcs = (r < 45) ? DCS_SEPTET : (r < 90) ? DCS_UCS2 : 5'($urandom);
    w = (dcs == DCS_UCS2) ? 16 : 7;
    r = $urandom_range(99);
    if (r < 5) n = (dcs == DCS_UCS2) ? 70 : 160;
    else if (r < 8) n = (dcs == DCS_UCS2) ? $urandom_range(71, 255) : $urandom_range(161, 255);
    else n = $urandom_range(0, 12);
    concat = ($urandom_range(99) < 40);
    put_bits(dcs, 5);
    put_bits(n, 8);
    if (n <= 160 && !(w == 16 && n > 70)) begin
      if (concat && n * w >= 24) begin
        put_bits(8'h05, 8); put_bits(8'h00, 8); put_bits(8'h03, 8);
        for (int k = 0; k < n * w - 24; k++) bitq.push_back($urandom_range(1));
      end else begin
        for (int k = 0; k < n * w; k++) bitq.push_back($urandom_range(1));
      end
    end
    pack_body();
    len = skew_len(body_q.size());
    if (len < 2 && $urandom_range(3) != 0) len = 2;
    pdu_q.push_back(SUB_USERDATA);
    pdu_q.push_back(len[7:0]);
    add_body(len);
  endfunction

  function automatic void add_timestamp();
    int len;
    len = ($urandom_range(99) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 8);
    pdu_q.push_back(SUB_TSTAMP);
    pdu_q.push_back(len[7:0]);
    for (int k = 0; k < len; k++) pdu_q.push_back(8'($urandom));
  endfunction

  function automatic void add_other();
    logic [7:0] t;
    int len;
    do t = 8'($urandom); while (t == SUB_USERDATA || t == SUB_TSTAMP);
    len = $urandom_range(0, 3);
    pdu_q.push_back(t);
    pdu_q.push_back(len[7:0]);
    for (int k = 0; k < len; k++) pdu_q.push_back(8'($urandom));
  endfunction

  // Build one PDU into pdu_q: mostly well formed, some broken or pure noise
  function automatic void build_pdu();
    int n, len, r;
    pdu_q.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) pdu_q.push_back(8'($urandom));
      return;
    end
    pdu_q.push_back(8'h00); pdu_q.push_back(8'h00); pdu_q.push_back(8'h02);
    pdu_q.push_back(8'h10); pdu_q.push_back(8'h02);
    pdu_q.push_back(OA_PARAM_ID);
    // address field
    put_bits(0, 2);
    if ($urandom_range(99) < 5) begin
      put_bits($urandom_range(ADDR_CAP, 255), 8);
      n = 0;
    end else begin
      n = ($urandom_range(9) == 0) ? ADDR_CAP - 1 : $urandom_range(0, 12);
      put_bits(n, 8);
      for (int k = 0; k < n; k++) put_bits($urandom_range(15), 4);
    end
    pack_body();
    len = skew_len(body_q.size());
    if ($urandom_range(99) < 3) body_q[0][7:6] = 2'($urandom_range(1, 3));
    pdu_q.push_back(len[7:0]);
    add_body(len);
    repeat (3) pdu_q.push_back(8'($urandom));
    pdu_q.push_back(BD_PARAM_ID);
    pdu_q.push_back(8'($urandom));
    // subparameters
    if ($urandom_range(3) == 0) add_other();
    if ($urandom_range(1)) begin
      add_user_data();
      if ($urandom_range(9) == 0) add_user_data();
      if ($urandom_range(4) == 0) add_other();
      add_timestamp();
    end else begin
      add_timestamp();
      add_user_data();
    end
    repeat ($urandom_range(0, 2)) pdu_q.push_back(8'($urandom));
    // occasional corruption or early end
    r = $urandom_range(99);
    if (r < 8) pdu_q[$urandom_range(pdu_q.size() - 1)] = 8'($urandom);
    else if (r < 14) while (pdu_q.size() > 1 && $urandom_range(3) != 0) void'(pdu_q.pop_back());
  endfunction

  initial begin
    cycles            = 0;
    bytes_sent        = 0;
    idle_pct          = 0;
    stall_pct         = 0;
    rst_ni            = 1'b0;
    pdu_if.valid      <= 1'b0;
    pdu_if.data_byte  <= 8'h00;
    pdu_if.end_of_pdu <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: header errors, early end, all-ones byte, bad address id
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h55, 1'b1);
    pdu_q = '{8'h00, 8'h00, 8'h02, 8'h10, 8'h02, 8'h07, 8'haa};
    send_pdu();
    pdu_q = '{8'h00, 8'h00, 8'h02, 8'h10, 8'h02, 8'h02, 8'h01};
    send_pdu();
    pdu_q = '{8'h00, 8'h00, 8'h02, 8'h10, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h09, 8'h00};
    send_pdu();

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      while (bytes_sent < 40 * (ph + 1) + 20) begin
        build_pdu();
        send_pdu();
      end
      if (ph == 1) begin
        // hold off until the result queue is empty
        pdu_if.valid <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end
    end

    pdu_if.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_cdma_sms_pdu_parser: PASS");
    else
      $display("tb_cdma_sms_pdu_parser: FAIL");
    $finish;
  end
endmodule

### sim.f
hw/rtl/csp_pkg.sv
hw/rtl/csp_in_if.sv
hw/rtl/csp_out_if.sv
hw/rtl/cdma_sms_pdu_parser.sv
tb/tb_cdma_sms_pdu_parser.sv
